FILE: sv/rm2eul_pkg.sv
// Shared widths, types and CORDIC helpers for the rotation matrix to Euler angle block.
`default_nettype none

package rm2eul_pkg;

  // field and bus widths
  localparam int MW          = 18;            // matrix element, signed Q1.16
  localparam int AW          = 16;            // output angle, signed Q3.13
  localparam int TW          = 17;            // threshold, unsigned Q1.16
  localparam int S_TDATA_W   = 128;           // seven elements, padded to bytes
  localparam int M_TDATA_W   = 3 * AW;
  localparam int M_TUSER_W   = 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // datapath widths
  localparam int GUARD_BITS    = 14;          // Q1.16 -> Q.30
  localparam int CW            = 36;          // CORDIC x/y, holds gain growth
  localparam int ZW            = 34;          // angle accumulator, Q.30 radians
  localparam int CORDIC_STAGES = 16;          // 8 .. 32
  localparam int XMW           = 34;          // clamped final x, unsigned
  localparam int SPLIT         = 17;          // low half of the split multiply
  localparam int GW            = 30;          // width of the inverse gain
  localparam int PROD_W        = XMW - SPLIT + GW;
  localparam int SUM_W         = XMW + GW + 1;
  localparam int MAGW          = XMW;         // magnitude, Q.30
  localparam int SYW           = MAGW + 1 - GUARD_BITS;
  localparam int OUT_SHIFT     = 17;          // Q.30 -> Q3.13

  localparam logic [GW-1:0]        INV_GAIN    = 30'd652032874;
  localparam logic signed [ZW-1:0] ANG_PI_HALF = 34'sd1686629713;
  localparam int                   ANG_OUT_MAX = 25736;

  // register map
  localparam logic [PADDR_W-1:0] REG_SINGULAR_THRESHOLD = 3'd0;
  localparam logic [TW-1:0]      THRESHOLD_RESET        = 17'd1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;   // atan2(0, 0): angle forced to 0
  } cordic_t;

  // elements needed after the yaw/magnitude pass
  typedef struct packed {
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m12;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic [AW-1:0] roll;
    logic [AW-1:0] pitch;
    logic [AW-1:0] yaw;
    logic          singular;
  } result_t;

  // atan(2^-i) in Q.30, rounded to nearest
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic [ZW-1:0] r;
    case (idx)
      5'd0:  r = 34'd843314857;
      5'd1:  r = 34'd497837829;
      5'd2:  r = 34'd263043836;
      5'd3:  r = 34'd133525159;
      5'd4:  r = 34'd67021687;
      5'd5:  r = 34'd33543516;
      5'd6:  r = 34'd16775851;
      5'd7:  r = 34'd8388437;
      5'd8:  r = 34'd4194283;
      5'd9:  r = 34'd2097149;
      5'd10: r = 34'd1048576;
      5'd11: r = 34'd524288;
      5'd12: r = 34'd262144;
      5'd13: r = 34'd131072;
      5'd14: r = 34'd65536;
      5'd15: r = 34'd32768;
      5'd16: r = 34'd16384;
      5'd17: r = 34'd8192;
      5'd18: r = 34'd4096;
      5'd19: r = 34'd2048;
      5'd20: r = 34'd1024;
      5'd21: r = 34'd512;
      5'd22: r = 34'd256;
      5'd23: r = 34'd128;
      5'd24: r = 34'd64;
      5'd25: r = 34'd32;
      5'd26: r = 34'd16;
      5'd27: r = 34'd8;
      5'd28: r = 34'd4;
      5'd29: r = 34'd2;
      5'd30: r = 34'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CW-1:0] scale_in(input logic signed [MW-1:0] v);
    logic signed [CW-1:0] t;
    t = CW'(v);
    return t <<< GUARD_BITS;
  endfunction

  // zero check and quarter turn into the right half plane
  function automatic cordic_t cordic_init(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        r.x = y;
        r.y = -x;
        r.z = ANG_PI_HALF;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -ANG_PI_HALF;
      end
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  // one vectoring micro-rotation; k is a constant per pipeline stage
  function automatic cordic_t cordic_iter(input cordic_t s, input int unsigned k);
    cordic_t              r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [ZW-1:0]        a;
    dx = $signed(s.y) >>> k;
    dy = $signed(s.x) >>> k;
    a  = atan_lut(5'(k));
    r  = s;
    if (!s.y[CW-1]) begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + a;
    end else begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - a;
    end
    return r;
  endfunction

  // Q.30 -> Q3.13, round half up, saturate
  function automatic logic [AW-1:0] angle_out(input logic signed [ZW-1:0] z);
    logic signed [ZW:0]           t;
    logic signed [ZW-OUT_SHIFT:0] a;
    logic [AW-1:0]                r;
    t = $signed({z[ZW-1], z}) + $signed((ZW+1)'(1 << (OUT_SHIFT - 1)));
    a = t[ZW:OUT_SHIFT];
    if (a > (ZW-OUT_SHIFT+1)'(ANG_OUT_MAX)) begin
      r = AW'(ANG_OUT_MAX);
    end else if (a < (ZW-OUT_SHIFT+1)'(-ANG_OUT_MAX)) begin
      r = AW'(-ANG_OUT_MAX);
    end else begin
      r = a[AW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rotation_matrix_to_euler_zyx.sv
// Rotation matrix to ZYX Euler angles with pipelined CORDIC vectoring units.
//
//  port group   dir   contents
//  s_axis_*     in    matrix word: seven Q1.16 elements
//  m_axis_*     out   angle word: roll, pitch, yaw (Q3.13) and singular flag
//  APB          in    singular_threshold at byte address 0
//
//  One word per cycle while the skid register is empty; the yaw CORDIC chain, the
//  split magnitude multiply and the pitch/roll chain lie in series.
//  Reset clears the valid bits and the output/skid flags; the threshold resets to 1.
//  A stalled output takes one more word into the skid register, then the whole
//  pipeline freezes until the skid drains.
`default_nettype none

module rotation_matrix_to_euler_zyx (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // fields low to high: mat_r0c0, mat_r1c0, mat_r1c1, mat_r1c2, mat_r2c0,
  // mat_r2c1, mat_r2c2 (18 bits each), 2 pad bits
  input  logic [rm2eul_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // fields low to high: roll_angle, pitch_angle, yaw_angle (16 bits each)
  output logic [rm2eul_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // fields low to high: is_singular
  output logic [rm2eul_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rm2eul_pkg::PADDR_W-1:0]       paddr,
  input  logic [rm2eul_pkg::PDATA_W-1:0]       pwdata,
  output logic [rm2eul_pkg::PDATA_W-1:0]       prdata,
  output logic                                 pready
);
  import rm2eul_pkg::*;

  localparam int N = CORDIC_STAGES;

  // ---------------- configuration ----------------
  logic [TW-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SINGULAR_THRESHOLD) ? PDATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == REG_SINGULAR_THRESHOLD)) begin
      thr_q <= pwdata[TW-1:0];
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic skid_v_q;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // ---------------- input split ----------------
  logic signed [MW-1:0] in_m00, in_m10;
  mat_t                 in_mat;

  assign in_m00     = s_axis_tdata[0*MW +: MW];
  assign in_m10     = s_axis_tdata[1*MW +: MW];
  assign in_mat.m11 = s_axis_tdata[2*MW +: MW];
  assign in_mat.m12 = s_axis_tdata[3*MW +: MW];
  assign in_mat.m20 = s_axis_tdata[4*MW +: MW];
  assign in_mat.m21 = s_axis_tdata[5*MW +: MW];
  assign in_mat.m22 = s_axis_tdata[6*MW +: MW];

  // ---------------- yaw / magnitude chain ----------------
  cordic_t       yaw_q   [N+1];
  mat_t          yaw_m_q [N+1];
  logic [N:0]    yaw_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_v_q[0] <= 1'b0;
    end else if (en) begin
      yaw_v_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q[0]   <= cordic_init(scale_in(in_m00), scale_in(in_m10));
      yaw_m_q[0] <= in_mat;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_yaw
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        yaw_v_q[g+1] <= 1'b0;
      end else if (en) begin
        yaw_v_q[g+1] <= yaw_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        yaw_q[g+1]   <= cordic_iter(yaw_q[g], g);
        yaw_m_q[g+1] <= yaw_m_q[g];
      end
    end
  end

  // ---------------- magnitude: x * 1/K in two halves ----------------
  logic [XMW-1:0]       xc;
  logic [PROD_W-1:0]    p_lo_q, p_hi_q;
  logic [ZW-1:0]        m1_z_q, m2_z_q, m3_z_q;
  mat_t                 m1_mat_q, m2_mat_q, m3_mat_q;
  logic [MAGW-1:0]      m2_mag_q, m3_mag_q;
  logic                 m3_sing_q;
  logic [2:0]           m_v_q;
  logic [SUM_W-1:0]     mag_sum;
  logic [MAGW:0]        sy_sum;
  logic [SYW-1:0]       sy_q16;

  assign xc      = yaw_q[N].x[CW-1] ? '0 : yaw_q[N].x[XMW-1:0];
  assign mag_sum = (SUM_W'(p_hi_q) << SPLIT) + SUM_W'(p_lo_q) + SUM_W'(1 << (GW - 1));
  assign sy_sum  = {1'b0, m2_mag_q} + (MAGW+1)'(1 << (GUARD_BITS - 1));
  assign sy_q16  = sy_sum[MAGW:GUARD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= '0;
    end else if (en) begin
      m_v_q <= {m_v_q[1:0], yaw_v_q[N]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_lo_q    <= PROD_W'(xc[SPLIT-1:0] * INV_GAIN);
      p_hi_q    <= PROD_W'(xc[XMW-1:SPLIT] * INV_GAIN);
      m1_z_q    <= yaw_q[N].zero ? '0 : yaw_q[N].z;
      m1_mat_q  <= yaw_m_q[N];
      m2_mag_q  <= mag_sum[GW +: MAGW];
      m2_z_q    <= m1_z_q;
      m2_mat_q  <= m1_mat_q;
      m3_mag_q  <= m2_mag_q;
      m3_sing_q <= sy_q16 < SYW'(thr_q);
      m3_z_q    <= m2_z_q;
      m3_mat_q  <= m2_mat_q;
    end
  end

  // ---------------- pitch and roll chains ----------------
  typedef struct packed {
    logic [ZW-1:0] yaw_z;
    logic          singular;
  } side_t;

  cordic_t              pit_q  [N+1];
  cordic_t              rol_q  [N+1];
  side_t                side_q [N+1];
  logic [N:0]           pr_v_q;
  logic signed [CW-1:0] roll_x, roll_y;

  assign roll_x = m3_sing_q ? scale_in(m3_mat_q.m11)  : scale_in(m3_mat_q.m22);
  assign roll_y = m3_sing_q ? -scale_in(m3_mat_q.m12) : scale_in(m3_mat_q.m21);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q[0] <= 1'b0;
    end else if (en) begin
      pr_v_q[0] <= m_v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pit_q[0]           <= cordic_init(CW'(m3_mag_q), -scale_in(m3_mat_q.m20));
      rol_q[0]           <= cordic_init(roll_x, roll_y);
      side_q[0].yaw_z    <= m3_sing_q ? '0 : m3_z_q;
      side_q[0].singular <= m3_sing_q;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_pr
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pr_v_q[g+1] <= 1'b0;
      end else if (en) begin
        pr_v_q[g+1] <= pr_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pit_q[g+1]  <= cordic_iter(pit_q[g], g);
        rol_q[g+1]  <= cordic_iter(rol_q[g], g);
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // ---------------- format, output register and skid ----------------
  result_t res_d;
  result_t out_q, skid_q;
  logic    out_v_q;

  assign res_d.roll     = angle_out(rol_q[N].zero ? '0 : rol_q[N].z);
  assign res_d.pitch    = angle_out(pit_q[N].zero ? '0 : pit_q[N].z);
  assign res_d.yaw      = angle_out(side_q[N].yaw_z);
  assign res_d.singular = side_q[N].singular;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (!out_v_q || m_axis_tready) begin
        out_v_q <= pr_v_q[N];
      end else if (pr_v_q[N]) begin
        skid_v_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_v_q || m_axis_tready) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (m_axis_tready) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.yaw, out_q.pitch, out_q.roll};
  assign m_axis_tuser  = out_q.singular;

`ifndef NO_ASSERTIONS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_yaw_singular : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[3*AW-1:2*AW] == '0))
    else $error("yaw not zero in gimbal lock");

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[AW-1:0]) <= $signed(AW'(ANG_OUT_MAX)) &&
                       $signed(m_axis_tdata[AW-1:0]) >= $signed(AW'(-ANG_OUT_MAX))))
    else $error("roll outside the saturation range");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the rotation matrix to ZYX Euler angle block.
`timescale 1ns / 100ps

module tb_top;
  import rm2eul_pkg::*;

  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int          ONE_Q16      = 65536;
  localparam int          FIELD_MAX    = 131071;
  localparam int          FIELD_MIN    = -131072;
  localparam longint      GUARD_SCALE  = 64'sd16384;   // Q1.16 -> Q.30
  localparam longint      HALF_PI_Q30  = 64'sd1686629713;
  localparam longint      GAIN_RECIP   = 64'sd652032874; // 1/K, Q.30
  localparam longint      ANGLE_LIMIT  = 64'sd25736;
  localparam real         PI_R         = 3.141592653589793;
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  typedef enum logic [1:0] {POSE_RANDOM, POSE_NEAR_LOCK, RAW_FULL, RAW_SMALL} matrix_kind_e;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor state and run bookkeeping
  logic [TW-1:0] thr_model = 17'd1;
  longint        arctan_q30 [32];
  result_t       pending_angles [$];
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  bit            sink_blocked = 1'b0;
  int unsigned   rx_wait = 0;
  int unsigned   errors = 0;
  int unsigned   sent_words = 0;
  int unsigned   checked_words = 0;
  int unsigned   lock_words = 0;
  int unsigned   thr_settings = 0;
  int unsigned   input_stalls = 0;

  always #10 clk_i = ~clk_i;

  rotation_matrix_to_euler_zyx dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  task automatic flag_mismatch(input string what);
    if (errors < MAX_PRINTS) begin
      $display("%0t MISMATCH %s", $realtime, what);
    end
    errors++;
  endtask

  // ---------------------------------------------------------------- predictor

  // atan2(y, x) in Q.30 with the vectoring magnitude (Q.30, gain removed)
  function automatic longint vector_angle(input longint x0, input longint y0,
                                          output logic [63:0] mag);
    longint      x, y, z, dx, dy;
    logic [63:0] ux;
    x = x0;
    y = y0;
    z = 0;
    if (x0 == 0 && y0 == 0) begin
      mag = '0;
      return 0;
    end
    // left half plane: exact quarter turn first
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x = y0;
        y = -x0;
        z = HALF_PI_Q30;
      end else begin
        x = -y0;
        y = x0;
        z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_q30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_q30[i];
      end
    end
    if (x < 0) x = 0;
    ux  = x;
    mag = (ux * 64'(GAIN_RECIP) + 64'd536870912) >> 30;
    return z;
  endfunction

  function automatic logic [AW-1:0] to_q3_13(input longint z);
    longint a;
    a = (z + 65536) >>> 17;
    if (a > ANGLE_LIMIT) begin
      a = ANGLE_LIMIT;
    end else if (a < -ANGLE_LIMIT) begin
      a = -ANGLE_LIMIT;
    end
    return a[AW-1:0];
  endfunction

  function automatic result_t predict_euler(input logic [S_TDATA_W-1:0] word);
    longint      elem [7];
    logic [63:0] sy, sy_q16, spare;
    longint      yaw, roll, pitch;
    result_t     r;
    for (int k = 0; k < 7; k++) begin
      elem[k] = longint'($signed(word[MW*k +: MW])) * GUARD_SCALE;
    end
    yaw        = vector_angle(elem[0], elem[1], sy);
    sy_q16     = (sy + 64'd8192) >> GUARD_BITS;
    r.singular = sy_q16 < 64'(thr_model);
    pitch      = vector_angle(longint'(sy), -elem[4], spare);
    if (r.singular) begin
      // gimbal lock: roll from the middle row, yaw pinned
      roll = vector_angle(elem[2], -elem[3], spare);
      yaw  = 0;
    end else begin
      roll = vector_angle(elem[6], elem[5], spare);
    end
    r.roll  = to_q3_13(roll);
    r.pitch = to_q3_13(pitch);
    r.yaw   = to_q3_13(yaw);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [S_TDATA_W-1:0] pack_matrix(input int r0c0, r1c0, r1c1, r1c2,
                                                       r2c0, r2c1, r2c2);
    return {2'b00, 18'(r2c2), 18'(r2c1), 18'(r2c0), 18'(r1c2), 18'(r1c1), 18'(r1c0),
            18'(r0c0)};
  endfunction

  function automatic int to_q1_16(input real v);
    return int'(v * 65536.0);
  endfunction

  function automatic real rand_unit();
    return $urandom / 4294967296.0;
  endfunction

  // R = Rz(yaw) * Ry(pitch) * Rx(roll)
  function automatic logic [S_TDATA_W-1:0] pose_matrix(input real rl, input real pt,
                                                       input real yw);
    real cr, sr, cp, sp, cy, syw;
    cr  = $cos(rl);
    sr  = $sin(rl);
    cp  = $cos(pt);
    sp  = $sin(pt);
    cy  = $cos(yw);
    syw = $sin(yw);
    return pack_matrix(to_q1_16(cy * cp), to_q1_16(syw * cp),
                       to_q1_16(syw * sp * sr + cy * cr), to_q1_16(syw * sp * cr - cy * sr),
                       to_q1_16(-sp), to_q1_16(cp * sr), to_q1_16(cp * cr));
  endfunction

  function automatic logic [S_TDATA_W-1:0] random_matrix(input matrix_kind_e kind);
    real pt;
    case (kind)
      POSE_RANDOM: begin
        return pose_matrix((2.0 * rand_unit() - 1.0) * PI_R,
                           (2.0 * rand_unit() - 1.0) * PI_R / 2.0,
                           (2.0 * rand_unit() - 1.0) * PI_R);
      end
      POSE_NEAR_LOCK: begin
        pt = PI_R / 2.0 - rand_unit() * 0.02;
        if ($urandom_range(0, 1) == 0) pt = -pt;
        return pose_matrix((2.0 * rand_unit() - 1.0) * PI_R, pt,
                           (2.0 * rand_unit() - 1.0) * PI_R);
      end
      RAW_FULL: begin
        return pack_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
      end
      default: begin
        return pack_matrix(int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024);
      end
    endcase
  endfunction

  function automatic matrix_kind_e pick_kind();
    int unsigned roll_dice;
    roll_dice = $urandom_range(0, 9);
    if (roll_dice < 5) return POSE_RANDOM;
    if (roll_dice < 7) return POSE_NEAR_LOCK;
    if (roll_dice < 9) return RAW_FULL;
    return RAW_SMALL;
  endfunction

  task automatic send_word(input logic [S_TDATA_W-1:0] word);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_angles.push_back(predict_euler(word));
    sent_words++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_angles.size() != 0);
  endtask

  // ---------------------------------------------------------------- register port

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      flag_mismatch($sformatf("readback addr %0d got %h want %h", addr, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // only called with the pipeline empty
  task automatic set_threshold(input logic [PDATA_W-1:0] value);
    drain();
    apb_write(REG_SINGULAR_THRESHOLD, value);
    thr_model = value[TW-1:0];
    thr_settings++;
    apb_read_check(REG_SINGULAR_THRESHOLD, PDATA_W'(thr_model));
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     want;
    int unsigned w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      w = rx_wait;
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
      if (m_axis_tvalid && m_axis_tready) begin
        checked_words++;
        if (m_axis_tuser[0]) lock_words++;
        if (pending_angles.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h/%b", m_axis_tdata, m_axis_tuser));
        end else begin
          want = pending_angles.pop_front();
          if (m_axis_tdata[AW-1:0] !== want.roll)
            flag_mismatch($sformatf("word %0d roll got %0d want %0d", checked_words,
                                    $signed(m_axis_tdata[AW-1:0]), $signed(want.roll)));
          if (m_axis_tdata[2*AW-1:AW] !== want.pitch)
            flag_mismatch($sformatf("word %0d pitch got %0d want %0d", checked_words,
                                    $signed(m_axis_tdata[2*AW-1:AW]), $signed(want.pitch)));
          if (m_axis_tdata[3*AW-1:2*AW] !== want.yaw)
            flag_mismatch($sformatf("word %0d yaw got %0d want %0d", checked_words,
                                    $signed(m_axis_tdata[3*AW-1:2*AW]), $signed(want.yaw)));
          if (m_axis_tuser[0] !== want.singular)
            flag_mismatch($sformatf("word %0d singular got %b want %b", checked_words,
                                    m_axis_tuser[0], want.singular));
        end
        w = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (sink_blocked) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= w;
      end else if (w != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= w - 1;
      end else begin
        m_axis_tready <= 1'b1;
        rx_wait       <= 0;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_register_access();
    apb_read_check(REG_SINGULAR_THRESHOLD, PDATA_W'(THRESHOLD_RESET));
    // a write to an unmapped address must leave the threshold alone
    apb_write(UNMAPPED_ADDR, 32'h0001_FFFF);
    apb_read_check(REG_SINGULAR_THRESHOLD, PDATA_W'(THRESHOLD_RESET));
  endtask

  task automatic test_directed_corners();
    send_word(pack_matrix(ONE_Q16, 0, ONE_Q16, 0, 0, 0, ONE_Q16));
    send_word(pack_matrix(0, 0, 0, 0, 0, 0, 0));                   // every vector zero
    send_word(pack_matrix(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16));
    send_word(pack_matrix(-ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16, -ONE_Q16,
                          -ONE_Q16));
    send_word(pack_matrix(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                          FIELD_MAX));
    send_word(pack_matrix(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                          FIELD_MIN));
    send_word(pack_matrix(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX,
                          FIELD_MIN));
    // left half plane, both turn directions, and yaw right at +pi
    send_word(pack_matrix(-ONE_Q16, 1, ONE_Q16, 0, 0, 0, ONE_Q16));
    send_word(pack_matrix(-ONE_Q16, -1, ONE_Q16, 0, 0, 0, ONE_Q16));
    send_word(pack_matrix(-ONE_Q16, 0, ONE_Q16, 0, 0, 0, ONE_Q16));
    send_word(pack_matrix(-1, 0, ONE_Q16, 0, 0, 0, ONE_Q16));
    // gimbal lock, pitch at +90 and -90 degrees
    send_word(pack_matrix(0, 0, 46341, -46341, -ONE_Q16, 0, 0));
    send_word(pack_matrix(0, 0, -46341, 46341, ONE_Q16, 0, 0));
    send_word(pack_matrix(0, 0, 0, 0, FIELD_MIN, 0, 0));
    // one-lsb column: just clears the reset threshold
    send_word(pack_matrix(0, 1, ONE_Q16, 0, 0, 0, ONE_Q16));
    send_word(pack_matrix(1, 0, 0, 0, 0, 100, -200));
    // roll from the left half plane
    send_word(pack_matrix(ONE_Q16, 0, ONE_Q16, 0, 0, 30000, -50000));
    send_word(pack_matrix(ONE_Q16, 0, ONE_Q16, 0, 0, -30000, -50000));
    drain();
  endtask

  task automatic test_threshold_sweep();
    logic [PDATA_W-1:0] level;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       level = 32'd0;                         // never singular
        1:       level = 32'hFFFF_0000;                 // 65536 with junk above bit 16
        2:       level = 32'd46341;
        3:       level = PDATA_W'($urandom_range(1, ONE_Q16 - 1));
        default: level = 32'd300;
      endcase
      set_threshold(level);
      tx_idle = p[0];
      rx_idle = p[1];
      send_word(pack_matrix(0, 0, 0, 0, 0, 0, 0));
      send_word(pack_matrix(int'(thr_model), 0, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      send_word(pack_matrix(int'(thr_model) - 1, 0, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      send_word(pack_matrix(0, -int'(thr_model), $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      for (int n = 0; n < 36; n++) begin
        send_word(random_matrix(n[0] ? POSE_NEAR_LOCK : pick_kind()));
      end
    end
    drain();
  endtask

  task automatic test_random_poses();
    logic [1:0] mode;
    set_threshold(PDATA_W'($urandom_range(256, 4096)));
    for (int n = 0; n < 480; n++) begin
      // reshuffle who idles, including stretches with no gaps at all
      if (n % 60 == 0) begin
        mode    = 2'($urandom_range(0, 3));
        tx_idle = mode[0];
        rx_idle = mode[1];
      end
      send_word(random_matrix(pick_kind()));
    end
    drain();
  endtask

  task automatic test_backpressure();
    set_threshold(PDATA_W'(THRESHOLD_RESET));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    fork
      begin
        sink_blocked <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_blocked <= 1'b0;
      end
      begin
        for (int n = 0; n < 120; n++) begin
          send_word(random_matrix(pick_kind()));
        end
      end
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) begin
      arctan_q30[i] = longint'($atan(1.0 / (2.0 ** i)) * 1073741824.0);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_corners();
    test_threshold_sweep();
    test_random_poses();
    test_backpressure();

    repeat (2 * CORDIC_STAGES + 10) @(posedge clk_i);
    $display("checked %0d of %0d matrices, %0d in gimbal lock, over %0d threshold writes",
             checked_words, sent_words, lock_words, thr_settings);
    $display("input held off for %0d cycles by output backpressure", input_stalls);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d words outstanding", pending_angles.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
